>>> rtl/core/tprd_pkg.sv
// shared types and constants of the tile plane repeat decoder
package tprd_pkg;

  localparam int unsigned ROWS = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [7:0] REPEAT_MASK = 8'h7F;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_ROW0,
    PH_LIT
  } phase_t;

  typedef struct packed {
    logic            transpose;
    logic [7:0][7:0] rows;
  } plane_t;

  // byte idx of a finished plane, as stored or bit transposed
  function automatic logic [7:0] plane_byte(input plane_t p, input logic [2:0] idx);
    logic [7:0] v;
    v = '0;
    if (p.transpose) begin
      for (int r = 0; r < 8; r++) begin
        v[7 - r] = p.rows[r][~idx];
      end
    end else begin
      v = p.rows[idx];
    end
    return v;
  endfunction

endpackage

>>> rtl/core/tprd_front.sv
// front end: parses command and literal bytes and assembles complete planes
module tprd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            q_full,
  output logic            q_push,
  output tprd_pkg::plane_t q_plane
);

  tprd_pkg::phase_t phase, phase_next;
  logic [7:0]       command_bits;
  logic [2:0]       row_index, row_index_next;
  logic [7:0][7:0]  rows;
  logic [7:0][7:0]  rows_new;
  logic [2:0]       cur_row;
  logic [7:0]       pend;
  logic [3:0]       next_lit;
  logic             plane_done;
  logic             accept;

  assign in_ready = (phase == tprd_pkg::PH_CMD) || !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cur_row  = (phase == tprd_pkg::PH_ROW0) ? 3'd0 : row_index;
    // command bits of the rows after the current one
    pend     = command_bits & (tprd_pkg::REPEAT_MASK >> cur_row);
    next_lit = 4'd8;
    for (int k = 7; k >= 1; k--) begin
      if (pend[7 - k]) begin
        next_lit = 4'(k);
      end
    end
    plane_done = (pend == 8'h00);
    // the byte fills its own row and every repeat up to the next literal
    for (int k = 0; k < 8; k++) begin
      if ((4'(k) >= {1'b0, cur_row}) && (4'(k) < next_lit)) begin
        rows_new[k] = data_byte;
      end else begin
        rows_new[k] = rows[k];
      end
    end
  end

  always_comb begin
    phase_next     = phase;
    row_index_next = row_index;
    q_push         = 1'b0;
    if (accept) begin
      unique case (phase)
        tprd_pkg::PH_ROW0, tprd_pkg::PH_LIT: begin
          if (plane_done) begin
            phase_next     = tprd_pkg::PH_CMD;
            row_index_next = 3'd0;
            q_push         = 1'b1;
          end else begin
            phase_next     = tprd_pkg::PH_LIT;
            row_index_next = next_lit[2:0];
          end
        end
        default: begin
          phase_next     = tprd_pkg::PH_ROW0;
          row_index_next = 3'd0;
        end
      endcase
    end
  end

  assign q_plane.transpose = command_bits[7];
  assign q_plane.rows      = rows_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tprd_pkg::PH_CMD;
      row_index <= 3'd0;
    end else begin
      phase     <= phase_next;
      row_index <= row_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_bits <= 8'h00;
    end else if (accept && (phase == tprd_pkg::PH_CMD)) begin
      command_bits <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase != tprd_pkg::PH_CMD)) begin
      rows <= rows_new;
    end
  end

endmodule

>>> rtl/core/tprd_queue.sv
// short plane queue between front end and back end
module tprd_queue #(
  parameter int unsigned DEPTH = tprd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  tprd_pkg::plane_t           push_plane,
  input  logic                       pop,
  output tprd_pkg::plane_t           head,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tprd_pkg::plane_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_plane;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/tprd_back.sv
// back end: streams eight bytes of each queued plane through an output register
module tprd_back (
  input  logic             clk,
  input  logic             rst,
  input  tprd_pkg::plane_t head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_plane
);

  logic [2:0] idx;
  logic       load;

  assign load  = !q_empty && (!out_valid || out_ready);
  assign q_pop = load && (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= tprd_pkg::plane_byte(head, idx);
      last_of_plane <= (idx == 3'd7);
    end
  end

endmodule

>>> rtl/core/tile_plane_repeat_decoder_unit.sv
// top level of the tile plane repeat decoder
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid, in_ready, data_byte         | in
//  output  | out_valid, out_ready, out_byte,       | out
//          | last_of_plane                         |
//
// a plane of 2 to 9 input beats yields 8 output beats, one per cycle while out_ready is high
// the output rate is set by the back end, which reads one byte of the head plane per cycle
// while the plane queue is not empty and out_ready is high
// reset (synchronous, active high) clears the parser phase, queue pointers and output valid
// the front end stalls on any row 0 or literal byte while the plane queue is full;
// the back end stalls on out_ready and on an empty plane queue
module tile_plane_repeat_decoder_unit #(
  parameter int unsigned QDEPTH = tprd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_plane
);

  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  // plane hand-off between the two halves
  tprd_pkg::plane_t push_plane;
  tprd_pkg::plane_t head_plane;
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  logic             q_full;
  logic [CNT_W-1:0] q_count;

  // parser: command, row 0 and literal beats, repeats expanded into full planes
  tprd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_plane   (push_plane)
  );

  tprd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_plane (push_plane),
    .pop        (q_pop),
    .head       (head_plane),
    .empty      (q_empty),
    .full       (q_full),
    .count      (q_count)
  );

  // emitter: eight beats per plane, transposed when the command asked for it
  tprd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head_plane),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_plane (last_of_plane)
  );

  // a finished plane never meets a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("plane pushed into full queue");

  // the back end only retires a plane that is there
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("plane popped from empty queue");

  // retiring a plane coincides with loading its eighth beat
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (out_valid && last_of_plane))
    else $error("plane retired without its last beat");

  // occupancy grows by one on a lone push
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> (q_count == $past(q_count) + CNT_W'(1)))
    else $error("queue count out of step with pushes");

endmodule
